[hdl/mosaic_block_average_macros.svh]
// Assertion helpers for the block's built-in checks.
`ifndef MOSAIC_BLOCK_AVERAGE_MACROS_SVH
`define MOSAIC_BLOCK_AVERAGE_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define MBA_ASSERT_NOW(name, clk, rst, pre, post) \
   name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("mosaic_block_average: same-cycle check failed");

// Next-cycle implication, disabled in reset.
`define MBA_ASSERT_NEXT(name, clk, rst, pre, post) \
   name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("mosaic_block_average: next-cycle check failed");

`endif

[hdl/mba_pkg.sv]
package mba_pkg;

   // geometry limits
   localparam int MAX_WIDTH  = 4096;
   localparam int MAX_HEIGHT = 4096;
   localparam int MAX_BLOCK  = 64;

   // field widths
   localparam int PIX_W  = 8;
   localparam int AVG_W  = 8;
   localparam int DIM_W  = 13;
   localparam int BS_W   = 7;
   localparam int POS_W  = 12;
   localparam int CNT_W  = $clog2(MAX_BLOCK * MAX_BLOCK + 1);
   localparam int SUM_W  = $clog2(MAX_BLOCK * MAX_BLOCK * 255 + 1);
   localparam int X_W    = $clog2(MAX_WIDTH);
   localparam int Y_W    = $clog2(MAX_HEIGHT);
   localparam int OFF_W  = $clog2(MAX_BLOCK);
   localparam int ADDR_W = $clog2(MAX_WIDTH);
   localparam int STEP_W = $clog2(AVG_W);
   localparam int NCH    = 3;

   // register indices
   localparam logic [1:0] CSR_IMAGE_WIDTH  = 2'd0;
   localparam logic [1:0] CSR_IMAGE_HEIGHT = 2'd1;
   localparam logic [1:0] CSR_BLOCK_SIZE   = 2'd2;
   localparam logic [1:0] CSR_COLOR_MODE   = 2'd3;

   typedef enum logic [1:0] {
      DIV_IDLE,
      DIV_RUN,
      DIV_DONE
   } div_state_type;

   typedef logic [SUM_W-1:0] sum_type;
   typedef logic [AVG_W-1:0] avg_type;

   typedef struct packed {
      logic             valid;
      sum_type [NCH-1:0] sum;
      logic [CNT_W-1:0] cnt;
      logic [POS_W-1:0] block_col;
      logic [POS_W-1:0] block_row;
      logic             frame_end;
   } div_req_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

   typedef struct packed {
      avg_type [NCH-1:0] avg;
      logic [CNT_W-1:0]  cnt;
      logic [POS_W-1:0]  block_col;
      logic [POS_W-1:0]  block_row;
      logic              frame_end;
   } div_rsp_type;

endpackage

[hdl/mba_divider.sv]
// Restoring divider for the three channel means, one quotient bit per cycle.
module mba_divider (
   input  logic                  clock,
   input  logic                  reset,
   input  mba_pkg::div_req_type  div_req,
   input  logic                  div_take,
   output mba_pkg::div_stat_type div_stat,
   output mba_pkg::div_rsp_type  div_rsp
);
   import mba_pkg::*;

   div_state_type     state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   sum_type [NCH-1:0] rem_ff, rem_in;
   avg_type [NCH-1:0] quo_ff, quo_in;
   sum_type           dvs_ff, dvs_in;
   logic [CNT_W-1:0]  cnt_ff;
   logic [POS_W-1:0]  bcol_ff, brow_ff;
   logic              fend_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= DIV_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
      if (div_req.valid && state_ff == DIV_IDLE) begin
         cnt_ff  <= div_req.cnt;
         bcol_ff <= div_req.block_col;
         brow_ff <= div_req.block_row;
         fend_ff <= div_req.frame_end;
      end
   end

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      dvs_in   = dvs_ff;
      case (state_ff)
         DIV_IDLE: begin
            if (div_req.valid) begin
               state_in = DIV_RUN;
               step_in  = '0;
               rem_in   = div_req.sum;
               quo_in   = '0;
               // top quotient bit weight: divisor * 2^(AVG_W-1)
               dvs_in   = SUM_W'({{(SUM_W-CNT_W){1'b0}}, div_req.cnt} << (AVG_W - 1));
            end
         end
         DIV_RUN: begin
            for (int c = 0; c < NCH; c++) begin
               if (rem_ff[c] >= dvs_ff) begin
                  rem_in[c] = rem_ff[c] - dvs_ff;
                  quo_in[c] = {quo_ff[c][AVG_W-2:0], 1'b1};
               end else begin
                  quo_in[c] = {quo_ff[c][AVG_W-2:0], 1'b0};
               end
            end
            dvs_in  = dvs_ff >> 1;
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_W'(AVG_W - 1)) begin
               state_in = DIV_DONE;
            end
         end
         DIV_DONE: begin
            if (div_take) begin
               state_in = DIV_IDLE;
            end
         end
         default: begin
            state_in = DIV_IDLE;
         end
      endcase
   end

   assign div_stat.busy       = (state_ff != DIV_IDLE);
   assign div_stat.done       = (state_ff == DIV_DONE);
   assign div_rsp.avg         = quo_ff;
   assign div_rsp.cnt         = cnt_ff;
   assign div_rsp.block_col   = bcol_ff;
   assign div_rsp.block_row   = brow_ff;
   assign div_rsp.frame_end   = fend_ff;

endmodule

[hdl/mosaic_block_average.sv]
// Channel   | Direction | Handshake            | Payload
// req       | in        | req_valid/req_ready  | red_or_gray, green, blue
// rsp       | out       | rsp_valid/rsp_ready  | block position, means, count, frame_end
// csr       | in        | csr_wr_en            | csr_index, csr_wdata
//
// One pixel per cycle while no block completes. A pixel that closes a block
// holds the request side through one read-modify-write stage, eight divider
// steps and the handoff into the result register.
// The column-sum memory is read on accept and written in the next cycle; a
// one-entry forward register covers the read that overlaps that write.
// Reset is synchronous; no memory clearing pass (first pixel of a block
// overwrites its entry). A stalled result occupies only the result register;
// the next completing block then waits in the divider and holds the request
// side until that result is taken.
module mosaic_block_average (
   input  logic        clock,
   input  logic        reset,
   // requests
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_red_or_gray,
   input  logic [7:0]  req_green,
   input  logic [7:0]  req_blue,
   // results
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [11:0] rsp_block_col,
   output logic [11:0] rsp_block_row,
   output logic [7:0]  rsp_avg_red_or_gray,
   output logic [7:0]  rsp_avg_green,
   output logic [7:0]  rsp_avg_blue,
   output logic [12:0] rsp_pixel_count,
   output logic        rsp_frame_end,
   // configuration
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_index,
   input  logic [12:0] csr_wdata
);
   import mba_pkg::*;
   `include "mosaic_block_average_macros.svh"

   localparam int MEM_W = NCH * SUM_W;

   // configuration registers
   logic [DIM_W-1:0] image_width_ff, image_height_ff;
   logic [BS_W-1:0]  block_size_ff;
   logic             color_mode_ff;
   logic             restart;

   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff  <= DIM_W'(640);
         image_height_ff <= DIM_W'(480);
         block_size_ff   <= BS_W'(8);
         color_mode_ff   <= 1'b1;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_IMAGE_WIDTH:  image_width_ff  <= csr_wdata[DIM_W-1:0];
            CSR_IMAGE_HEIGHT: image_height_ff <= csr_wdata[DIM_W-1:0];
            CSR_BLOCK_SIZE:   block_size_ff   <= csr_wdata[BS_W-1:0];
            CSR_COLOR_MODE:   color_mode_ff   <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         CSR_IMAGE_WIDTH, CSR_IMAGE_HEIGHT,
         CSR_BLOCK_SIZE, CSR_COLOR_MODE: restart = csr_wr_en;
         default:                        restart = 1'b0;
      endcase
   end

   // effective geometry: zero reads as one, large values saturate
   logic [DIM_W-1:0] width_eff, height_eff;
   logic [BS_W-1:0]  bs_eff;

   always_comb begin
      if (image_width_ff == '0)                      width_eff = DIM_W'(1);
      else if (image_width_ff > DIM_W'(MAX_WIDTH))   width_eff = DIM_W'(MAX_WIDTH);
      else                                           width_eff = image_width_ff;
      if (image_height_ff == '0)                     height_eff = DIM_W'(1);
      else if (image_height_ff > DIM_W'(MAX_HEIGHT)) height_eff = DIM_W'(MAX_HEIGHT);
      else                                           height_eff = image_height_ff;
      if (block_size_ff == '0)                       bs_eff = BS_W'(1);
      else if (block_size_ff > BS_W'(MAX_BLOCK))     bs_eff = BS_W'(MAX_BLOCK);
      else                                           bs_eff = block_size_ff;
   end

   // raster position counters
   logic [X_W-1:0]   pixel_x_ff, pixel_x_in;
   logic [Y_W-1:0]   pixel_y_ff, pixel_y_in;
   logic [OFF_W-1:0] col_in_block_ff, col_in_block_in;
   logic [OFF_W-1:0] row_in_band_ff, row_in_band_in;
   logic [POS_W-1:0] blk_col_ff, blk_col_in;
   logic [POS_W-1:0] blk_row_ff, blk_row_in;

   logic req_fire;
   logic x_last, y_last, col_wrap, row_wrap;
   logic [CNT_W-1:0] cnt_now;

   // pipeline stage 1: read data arrives, sums updated and written back
   logic             s1_valid_ff;
   logic             s1_first_ff;
   logic             s1_emit_ff;
   logic             s1_frame_end_ff;
   logic [ADDR_W-1:0] s1_addr_ff;
   logic [POS_W-1:0] s1_brow_ff;
   logic [CNT_W-1:0] s1_cnt_ff;
   logic [PIX_W-1:0] s1_pix_ff [NCH];

   div_req_type  div_req;
   div_stat_type div_stat;
   div_rsp_type  div_rsp;
   logic         div_take;

   assign req_ready = !div_stat.busy && !(s1_valid_ff && s1_emit_ff);
   assign req_fire  = req_valid && req_ready;

   assign x_last   = (({1'b0, pixel_x_ff}) + DIM_W'(1)) == width_eff;
   assign y_last   = (({1'b0, pixel_y_ff}) + DIM_W'(1)) == height_eff;
   assign col_wrap = (({1'b0, col_in_block_ff}) + BS_W'(1)) >= bs_eff;
   assign row_wrap = (({1'b0, row_in_band_ff}) + BS_W'(1)) >= bs_eff;
   assign cnt_now  = CNT_W'((({1'b0, col_in_block_ff}) + BS_W'(1))
                          * (({1'b0, row_in_band_ff}) + BS_W'(1)));

   always_comb begin
      pixel_x_in      = pixel_x_ff;
      pixel_y_in      = pixel_y_ff;
      col_in_block_in = col_in_block_ff;
      row_in_band_in  = row_in_band_ff;
      blk_col_in      = blk_col_ff;
      blk_row_in      = blk_row_ff;
      if (restart) begin
         pixel_x_in      = '0;
         pixel_y_in      = '0;
         col_in_block_in = '0;
         row_in_band_in  = '0;
         blk_col_in      = '0;
         blk_row_in      = '0;
      end else if (req_fire) begin
         if (x_last) begin
            pixel_x_in      = '0;
            col_in_block_in = '0;
            blk_col_in      = '0;
            if (y_last) begin
               pixel_y_in     = '0;
               row_in_band_in = '0;
               blk_row_in     = '0;
            end else begin
               pixel_y_in = pixel_y_ff + 1'b1;
               if (row_wrap) begin
                  row_in_band_in = '0;
                  blk_row_in     = blk_row_ff + 1'b1;
               end else begin
                  row_in_band_in = row_in_band_ff + 1'b1;
               end
            end
         end else begin
            pixel_x_in = pixel_x_ff + 1'b1;
            if (col_wrap) begin
               col_in_block_in = '0;
               blk_col_in      = blk_col_ff + 1'b1;
            end else begin
               col_in_block_in = col_in_block_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pixel_x_ff      <= '0;
         pixel_y_ff      <= '0;
         col_in_block_ff <= '0;
         row_in_band_ff  <= '0;
         blk_col_ff      <= '0;
         blk_row_ff      <= '0;
         s1_valid_ff     <= 1'b0;
      end else begin
         pixel_x_ff      <= pixel_x_in;
         pixel_y_ff      <= pixel_y_in;
         col_in_block_ff <= col_in_block_in;
         row_in_band_ff  <= row_in_band_in;
         blk_col_ff      <= blk_col_in;
         blk_row_ff      <= blk_row_in;
         s1_valid_ff     <= req_fire;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_first_ff     <= (row_in_band_ff == '0) && (col_in_block_ff == '0);
         s1_emit_ff      <= (col_wrap || x_last) && (row_wrap || y_last);
         s1_frame_end_ff <= x_last && y_last;
         s1_addr_ff      <= blk_col_ff[ADDR_W-1:0];
         s1_brow_ff      <= blk_row_ff;
         s1_cnt_ff       <= cnt_now;
         s1_pix_ff[0]    <= req_red_or_gray;
         // gray mode: green and blue enter the sums as zero
         s1_pix_ff[1]    <= color_mode_ff ? req_green : '0;
         s1_pix_ff[2]    <= color_mode_ff ? req_blue : '0;
      end
   end

   // column-sum memory, one entry per block column
   logic [MEM_W-1:0] sum_mem [MAX_WIDTH];
   logic [MEM_W-1:0] rd_data_ff;
   logic [MEM_W-1:0] wr_data;
   logic [MEM_W-1:0] fwd_data_ff;
   logic [ADDR_W-1:0] fwd_addr_ff;
   logic             fwd_valid_ff;
   logic [MEM_W-1:0] base;

   always_ff @(posedge clock) begin
      if (req_fire) begin
         rd_data_ff <= sum_mem[blk_col_ff[ADDR_W-1:0]];
      end
      if (s1_valid_ff) begin
         sum_mem[s1_addr_ff] <= wr_data;
      end
   end

   // the write landing on the read edge is not seen by that read
   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_valid_ff <= 1'b0;
      end else begin
         fwd_valid_ff <= s1_valid_ff;
      end
      fwd_addr_ff <= s1_addr_ff;
      fwd_data_ff <= wr_data;
   end

   always_comb begin
      if (s1_first_ff)                                       base = '0;
      else if (fwd_valid_ff && (fwd_addr_ff == s1_addr_ff))  base = fwd_data_ff;
      else                                                   base = rd_data_ff;
      for (int c = 0; c < NCH; c++) begin
         wr_data[c*SUM_W +: SUM_W] = base[c*SUM_W +: SUM_W]
                                   + {{(SUM_W-PIX_W){1'b0}}, s1_pix_ff[c]};
      end
   end

   always_comb begin
      div_req.valid     = s1_valid_ff && s1_emit_ff;
      for (int c = 0; c < NCH; c++) begin
         div_req.sum[c] = wr_data[c*SUM_W +: SUM_W];
      end
      div_req.cnt       = s1_cnt_ff;
      div_req.block_col = {{(POS_W-ADDR_W){1'b0}}, s1_addr_ff};
      div_req.block_row = s1_brow_ff;
      div_req.frame_end = s1_frame_end_ff;
   end

   mba_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .div_req  (div_req),
      .div_take (div_take),
      .div_stat (div_stat),
      .div_rsp  (div_rsp)
   );

   // result register
   logic             rsp_valid_ff;
   logic [POS_W-1:0] rsp_block_col_ff, rsp_block_row_ff;
   avg_type          rsp_avg_ff [NCH];
   logic [CNT_W-1:0] rsp_count_ff;
   logic             rsp_frame_end_ff;

   assign div_take = div_stat.done && (!rsp_valid_ff || rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (div_take) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (div_take) begin
         rsp_block_col_ff <= div_rsp.block_col;
         rsp_block_row_ff <= div_rsp.block_row;
         for (int c = 0; c < NCH; c++) begin
            rsp_avg_ff[c] <= div_rsp.avg[c];
         end
         rsp_count_ff     <= div_rsp.cnt;
         rsp_frame_end_ff <= div_rsp.frame_end;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_block_col       = rsp_block_col_ff;
   assign rsp_block_row       = rsp_block_row_ff;
   assign rsp_avg_red_or_gray = rsp_avg_ff[0];
   assign rsp_avg_green       = rsp_avg_ff[1];
   assign rsp_avg_blue        = rsp_avg_ff[2];
   assign rsp_pixel_count     = rsp_count_ff;
   assign rsp_frame_end       = rsp_frame_end_ff;

   // a completing pixel never finds the divider occupied
   `MBA_ASSERT_NOW(a_div_free, clock, reset, s1_valid_ff && s1_emit_ff, !div_stat.busy)
   // the divider picks up every completed block
   `MBA_ASSERT_NEXT(a_div_start, clock, reset, s1_valid_ff && s1_emit_ff, div_stat.busy)
   // the last pixel of a frame leaves the raster counters at the origin
   `MBA_ASSERT_NOW(a_frame_wrap, clock, reset, s1_valid_ff && s1_frame_end_ff,
      pixel_x_ff == '0 && pixel_y_ff == '0 && blk_row_ff == '0)

endmodule

[tb/sv/mosaic_block_average_checker.sv]
module mosaic_block_average_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_ready,
   input  logic [7:0]        req_red_or_gray,
   input  logic [7:0]        req_green,
   input  logic [7:0]        req_blue,
   input  logic              rsp_valid,
   input  logic              rsp_ready,
   input  logic [11:0]       rsp_block_col,
   input  logic [11:0]       rsp_block_row,
   input  logic [7:0]        rsp_avg_red_or_gray,
   input  logic [7:0]        rsp_avg_green,
   input  logic [7:0]        rsp_avg_blue,
   input  logic [12:0]       rsp_pixel_count,
   input  logic              rsp_frame_end,
   input  logic              csr_wr_en,
   input  logic [1:0]        csr_index,
   input  logic [12:0]       csr_wdata,
   output int unsigned       error_count,
   output int unsigned       pending_count,
   output int unsigned       checked_count
);
   import mba_pkg::*;

   typedef struct packed {
      logic [POS_W-1:0] block_col;
      logic [POS_W-1:0] block_row;
      avg_type          avg_red_or_gray;
      avg_type          avg_green;
      avg_type          avg_blue;
      logic [DIM_W-1:0] pixel_count;
      logic             frame_end;
   } block_mean_type;

   // shadow configuration
   logic [DIM_W-1:0] cfg_width;
   logic [DIM_W-1:0] cfg_height;
   logic [BS_W-1:0]  cfg_block;
   logic             cfg_rgb;

   // shadow scan state
   sum_type          band_sums [MAX_WIDTH][NCH];
   logic [X_W-1:0]   scan_x;
   logic [Y_W-1:0]   scan_y;
   logic [OFF_W-1:0] band_row;
   logic [OFF_W-1:0] block_offset;

   block_mean_type   expected_means [$];
   int unsigned      mismatches;
   int unsigned      compared;

   function automatic int unsigned clamp_dim(input int unsigned v, input int unsigned hi);
      if (v < 1) return 1;
      if (v > hi) return hi;
      return v;
   endfunction

   function automatic void compare_field(input string field, input logic [DIM_W-1:0] want,
                                         input logic [DIM_W-1:0] got);
      if (want !== got) begin
         $error("%s: expected %0d, got %0d", field, want, got);
         mismatches++;
      end
   endfunction

   function automatic void restart_scan();
      scan_x       = '0;
      scan_y       = '0;
      band_row     = '0;
      block_offset = '0;
   endfunction

   // accumulate one pixel; queue a block mean when it closes a block
   task automatic take_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
      int unsigned    w, h, bs, x, y, bc, cnt, col_off, row_off, c;
      int unsigned    chan [NCH];
      logic           last_col, last_row;
      block_mean_type m;
      w       = clamp_dim(cfg_width, MAX_WIDTH);
      h       = clamp_dim(cfg_height, MAX_HEIGHT);
      bs      = clamp_dim(cfg_block, MAX_BLOCK);
      chan[0] = r;
      chan[1] = cfg_rgb ? g : 8'd0;
      chan[2] = cfg_rgb ? b : 8'd0;
      x       = (scan_x < w) ? scan_x : w - 1;
      y       = (scan_y < h) ? scan_y : h - 1;
      bc      = (x / bs) % MAX_WIDTH;
      col_off = block_offset;
      row_off = band_row;
      for (c = 0; c < NCH; c++) begin
         if (row_off == 0 && col_off == 0)
            band_sums[bc][c] = chan[c];
         else
            band_sums[bc][c] = band_sums[bc][c] + chan[c];
      end
      last_col = (col_off + 1 >= bs) || (x == w - 1);
      last_row = (row_off + 1 >= bs) || (y == h - 1);
      if (last_col && last_row) begin
         cnt               = (col_off + 1) * (row_off + 1);
         m.block_col       = POS_W'(bc);
         m.block_row       = POS_W'(y / bs);
         m.avg_red_or_gray = avg_type'(band_sums[bc][0] / cnt);
         m.avg_green       = avg_type'(band_sums[bc][1] / cnt);
         m.avg_blue        = avg_type'(band_sums[bc][2] / cnt);
         m.pixel_count     = DIM_W'(cnt);
         m.frame_end       = (x == w - 1) && (y == h - 1);
         expected_means.push_back(m);
      end
      if (x == w - 1) begin
         scan_x       = '0;
         block_offset = '0;
         if (y == h - 1) begin
            scan_y   = '0;
            band_row = '0;
         end else begin
            scan_y   = Y_W'(y + 1);
            band_row = (row_off + 1 >= bs) ? '0 : OFF_W'(row_off + 1);
         end
      end else begin
         scan_x       = X_W'(x + 1);
         scan_y       = Y_W'(y);
         block_offset = (col_off + 1 >= bs) ? '0 : OFF_W'(col_off + 1);
      end
   endtask

   always @(posedge clock) begin
      block_mean_type m;
      if (reset) begin
         cfg_width  = 13'd640;
         cfg_height = 13'd480;
         cfg_block  = 7'd8;
         cfg_rgb    = 1'b1;
         restart_scan();
         expected_means.delete();
      end else begin
         // every index is a known register, so every write restarts the frame
         if (csr_wr_en) begin
            case (csr_index)
               CSR_IMAGE_WIDTH:  cfg_width  = csr_wdata;
               CSR_IMAGE_HEIGHT: cfg_height = csr_wdata;
               CSR_BLOCK_SIZE:   cfg_block  = csr_wdata[BS_W-1:0];
               CSR_COLOR_MODE:   cfg_rgb    = csr_wdata[0];
               default: ;
            endcase
            restart_scan();
         end
         if (req_valid && req_ready)
            take_pixel(req_red_or_gray, req_green, req_blue);
         if (rsp_valid && rsp_ready) begin
            if (expected_means.size() == 0) begin
               $error("unexpected block result: col %0d row %0d", rsp_block_col,
                      rsp_block_row);
               mismatches++;
            end else begin
               m = expected_means.pop_front();
               compared++;
               compare_field("block_col", m.block_col, rsp_block_col);
               compare_field("block_row", m.block_row, rsp_block_row);
               compare_field("avg_red_or_gray", m.avg_red_or_gray, rsp_avg_red_or_gray);
               compare_field("avg_green", m.avg_green, rsp_avg_green);
               compare_field("avg_blue", m.avg_blue, rsp_avg_blue);
               compare_field("pixel_count", m.pixel_count, rsp_pixel_count);
               compare_field("frame_end", m.frame_end, rsp_frame_end);
            end
         end
      end
      error_count   <= mismatches;
      pending_count <= expected_means.size();
      checked_count <= compared;
   end

endmodule

[tb/sv/tb_mosaic_block_average.sv]
module tb_mosaic_block_average;
   import mba_pkg::*;

   // Stimulus timing
   localparam int unsigned SETTLE_CYCLES = 24;        // outlasts the hold of a closing pixel
   localparam int unsigned HOLD_CYCLES   = 300;       // long receiver back-pressure
   localparam int unsigned RANDOM_ITEMS  = 220;
   localparam int unsigned CYCLE_LIMIT   = 5_000_000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;

   // request channel
   logic        req_valid       = 1'b0;
   logic        req_ready;
   logic [7:0]  req_red_or_gray = '0;
   logic [7:0]  req_green       = '0;
   logic [7:0]  req_blue        = '0;

   // result channel
   logic        rsp_valid;
   logic        rsp_ready       = 1'b0;
   logic [11:0] rsp_block_col;
   logic [11:0] rsp_block_row;
   logic [7:0]  rsp_avg_red_or_gray;
   logic [7:0]  rsp_avg_green;
   logic [7:0]  rsp_avg_blue;
   logic [12:0] rsp_pixel_count;
   logic        rsp_frame_end;

   // register port
   logic        csr_wr_en       = 1'b0;
   logic [1:0]  csr_index       = '0;
   logic [12:0] csr_wdata       = '0;

   // checker feedback
   int unsigned error_count;
   int unsigned pending_count;
   int unsigned checked_count;

   // bookkeeping for the summary
   int unsigned pixels_sent   = 0;
   int unsigned configs_done  = 0;
   int unsigned random_items  = 0;
   int unsigned cycle_count   = 0;

   // pacing controls; steady means no idling on that side
   logic        tx_steady     = 1'b0;
   logic        rsp_steady    = 1'b0;
   int unsigned hold_requests = 0;
   int unsigned holds_done    = 0;
   int unsigned hold_left     = 0;
   int unsigned ready_wait    = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   mosaic_block_average u_dut (.*);

   mosaic_block_average_checker u_checker (.*);

   // Mostly short gaps, now and then a long one.
   function automatic int unsigned pick_gap();
      if ($urandom_range(99, 0) < 85) return $urandom_range(3, 1);
      return $urandom_range(60, 15);
   endfunction

   // Sample values lean toward the extremes so averages hit 0 and 255.
   function automatic logic [7:0] rand_sample();
      case ($urandom_range(7, 0))
         0:       return 8'd0;
         1:       return 8'd255;
         default: return 8'($urandom_range(255, 0));
      endcase
   endfunction

   // Receiver: random stalls, a counted long hold-off on request from the
   // stimulus thread, or always ready during steady stretches.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left != 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (holds_done != hold_requests) begin
         holds_done <= holds_done + 1;
         hold_left  <= HOLD_CYCLES;
         rsp_ready  <= 1'b0;
      end else if (rsp_steady) begin
         rsp_ready <= 1'b1;
      end else if (ready_wait != 0) begin
         rsp_ready  <= 1'b0;
         ready_wait <= ready_wait - 1;
      end else if ($urandom_range(4, 0) == 0) begin
         rsp_ready  <= 1'b0;
         ready_wait <= pick_gap();
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Watchdog: a hung block or a lost result ends the run here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results still expected", cycle_count,
                  pending_count);
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // Offer one pixel and hold it until the block takes it. Valid is only
   // dropped when a gap is inserted, so back-to-back requests keep it high.
   task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
      int unsigned gap;
      gap = (tx_steady || $urandom_range(2, 0) != 0) ? 0 : pick_gap();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_red_or_gray <= r;
      req_green       <= g;
      req_blue        <= b;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pixels_sent++;
   endtask

   // Stream count pixels; flat sends full-scale white to max out the sums.
   task automatic send_frame(input int unsigned count, input logic flat);
      int unsigned i;
      for (i = 0; i < count; i++) begin
         if (flat)
            send_pixel(8'd255, 8'd255, 8'd255);
         else
            send_pixel(rand_sample(), rand_sample(), rand_sample());
      end
   endtask

   // Quiesce: stop offering, wait for every expected result, then give the
   // block time to finish any pixel that closes nothing.
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write all four registers back to back; only called when idle.
   task automatic configure(input logic [12:0] w, input logic [12:0] h,
                            input logic [6:0] bs, input logic rgb);
      csr_wr_en <= 1'b1;
      csr_index <= CSR_IMAGE_WIDTH;
      csr_wdata <= w;
      @(posedge clock);
      csr_index <= CSR_IMAGE_HEIGHT;
      csr_wdata <= h;
      @(posedge clock);
      csr_index <= CSR_BLOCK_SIZE;
      csr_wdata <= 13'(bs);
      @(posedge clock);
      csr_index <= CSR_COLOR_MODE;
      csr_wdata <= 13'(rgb);
      @(posedge clock);
      csr_wr_en <= 1'b0;
      configs_done++;
   endtask

   initial begin
      logic [12:0] w, h;
      logic [6:0]  bs;
      int unsigned n, count, round;

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // --- directed ---
      // Reset geometry (640x480, 8x8 RGB): a few pixels, no block closes.
      send_pixel(8'd255, 8'd0, 8'd255);
      send_pixel(8'd0, 8'd255, 8'd0);
      send_pixel(8'd128, 8'd127, 8'd1);
      send_pixel(8'd254, 8'd2, 8'd64);
      drain();

      // Zero width, height and block size read as 1: every pixel is a whole
      // frame of one block.
      configure(13'd0, 13'd0, 7'd0, 1'b1);
      send_pixel(8'd255, 8'd255, 8'd255);
      send_pixel(8'd0, 8'd0, 8'd0);
      send_pixel(8'd170, 8'd85, 8'd1);
      drain();

      // 3x2 frame in 2x2 blocks: a full block, then a partial one at the
      // right edge that is also the frame's last.
      configure(13'd3, 13'd2, 7'd2, 1'b1);
      send_pixel(8'd10, 8'd20, 8'd30);
      send_pixel(8'd11, 8'd21, 8'd31);
      send_pixel(8'd255, 8'd0, 8'd7);
      send_pixel(8'd12, 8'd22, 8'd32);
      send_pixel(8'd13, 8'd23, 8'd33);
      send_pixel(8'd0, 8'd255, 8'd9);
      drain();

      // Gray mode: green and blue must not leak into the result.
      configure(13'd2, 13'd2, 7'd2, 1'b0);
      send_pixel(8'd200, 8'd255, 8'd255);
      send_pixel(8'd201, 8'd255, 8'd255);
      send_pixel(8'd3, 8'd255, 8'd255);
      send_pixel(8'd4, 8'd255, 8'd255);
      drain();

      // Oversized block saturates to the maximum: one partial block.
      configure(13'd3, 13'd1, 7'd127, 1'b1);
      send_pixel(8'd255, 8'd1, 8'd100);
      send_pixel(8'd254, 8'd2, 8'd101);
      send_pixel(8'd253, 8'd3, 8'd102);
      drain();

      // --- geometry extremes ---
      // Width above the maximum, one row, unit blocks: each pixel closes a
      // block and the column index climbs with no frame end.
      configure(13'd8191, 13'd1, 7'd1, 1'b1);
      send_frame(16, 1'b0);
      drain();
      // Height above the maximum, one column: the row index climbs likewise.
      configure(13'd1, 13'd4500, 7'd1, 1'b0);
      send_frame(16, 1'b0);
      drain();
      // One full-width row in a maximum-size block, all white: the block
      // closes at the bottom edge with the largest sums a single row can give.
      configure(13'd64, 13'd1, 7'd64, 1'b1);
      send_frame(MAX_BLOCK, 1'b1);
      drain();

      // --- back-pressure ---
      // Receiver holds off while pixels keep coming, so the result side
      // fills and the block must stall its request input.
      configure(13'd16, 13'd4, 7'd2, 1'b1);
      tx_steady = 1'b1;
      hold_requests <= hold_requests + 1;
      send_frame(64, 1'b0);
      tx_steady = 1'b0;
      drain();

      // --- random frames ---
      // Mostly complete frames with random content; some frames cut short
      // by a reconfiguration, some run twice to cover frame wrap.
      round = 0;
      while (random_items < RANDOM_ITEMS) begin
         if ($urandom_range(15, 0) == 0) begin
            w = 13'($urandom_range(300, 25));
            h = 13'($urandom_range(3, 1));
         end else begin
            w = ($urandom_range(9, 0) == 0) ? 13'd0 : 13'($urandom_range(24, 1));
            h = ($urandom_range(9, 0) == 0) ? 13'd0 : 13'($urandom_range(12, 1));
         end
         case ($urandom_range(9, 0))
            0:       bs = 7'd0;
            1:       bs = 7'($urandom_range(127, 65));
            2:       bs = 7'd64;
            default: bs = 7'($urandom_range(8, 1));
         endcase
         configure(w, h, bs, 1'($urandom_range(1, 0)));
         n = (w == 0 ? 1 : w) * (h == 0 ? 1 : h);
         case ($urandom_range(9, 0))
            0, 1, 2: count = (n > 1) ? $urandom_range(n - 1, 1) : 1;
            3:       count = 2 * n;
            default: count = n;
         endcase
         // keep the total close to the item budget
         if (count > RANDOM_ITEMS - random_items)
            count = RANDOM_ITEMS - random_items;
         // one stretch with no idling on either side
         if (round == 1) begin
            tx_steady = 1'b1;
            rsp_steady <= 1'b1;
         end
         send_frame(count, 1'b0);
         random_items += count;
         drain();
         tx_steady = 1'b0;
         rsp_steady <= 1'b0;
         round++;
      end

      drain();
      $display("covered %0d pixels over %0d register settings, %0d random",
               pixels_sent, configs_done, random_items);
      $display("checked %0d block means, %0d mismatches", checked_count, error_count);
      if (error_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

[files.f]
+incdir+hdl
hdl/mba_pkg.sv
hdl/mba_divider.sv
hdl/mosaic_block_average.sv
tb/sv/mosaic_block_average_checker.sv
tb/sv/tb_mosaic_block_average.sv
